### rtl/ppvc_pkg.sv
package ppvc_pkg;

  // Operation codes handed from the front end to the back end
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_PURGE = 3'd1;
  localparam logic [2:0] OP_VALVE = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_TIME  = 3'd4;
  localparam logic [2:0] OP_IDENT = 3'd5;
  localparam logic [2:0] OP_STOP  = 3'd6;
  localparam logic [2:0] OP_ECHO  = 3'd7;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_BIG_O = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h6B;

  localparam logic [7:0]  TPS_RESET    = 8'd30;
  localparam logic [15:0] TIME_SAT     = 16'd999;
  localparam logic [1:0]  LEN_NONE     = 2'd0;
  localparam logic [1:0]  LEN_TWO      = 2'd2;
  localparam logic [1:0]  LEN_THREE    = 2'd3;
  localparam int          QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  arg0;
    logic [7:0]  arg1;
    logic [7:0]  arg2;
    logic [15:0] digits;
  } ppvc_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ppvc_qstat_t;

endpackage

### rtl/ppvc_if.sv
interface ppvc_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] command_byte;
  logic [7:0] arg_first;
  logic [7:0] arg_second;
  logic [7:0] arg_third;

  modport source(output valid, kind, command_byte, arg_first, arg_second, arg_third,
                 input ready);
  modport sink(input valid, kind, command_byte, arg_first, arg_second, arg_third,
               output ready);
endinterface

interface ppvc_rep_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_length;
  logic [7:0] reply_zero;
  logic [7:0] reply_one;
  logic [7:0] reply_two;
  logic       pump_on;
  logic       valve_to_sampler;
  logic       status_led;

  modport source(output valid, reply_length, reply_zero, reply_one, reply_two, pump_on,
                 valve_to_sampler, status_led, input ready);
  modport sink(input valid, reply_length, reply_zero, reply_one, reply_two, pump_on,
               valve_to_sampler, status_led, output ready);
endinterface

### rtl/ppvc_front.sv
module ppvc_front (
  ppvc_cmd_if.sink          cmd,
  input  ppvc_pkg::ppvc_qstat_t qstat,
  output logic              push,
  output ppvc_pkg::ppvc_entry_t entry
);
  import ppvc_pkg::*;

  logic [15:0] d_hund;
  logic [15:0] d_tens;
  logic [15:0] d_units;
  logic [15:0] acc;

  assign cmd.ready = !qstat.full;
  assign push      = cmd.valid && !qstat.full;

  // Digits parse in wrapping 16-bit arithmetic, no range check
  always_comb begin
    d_hund  = {8'd0, cmd.arg_first}  - {8'd0, CH_ZERO};
    d_tens  = {8'd0, cmd.arg_second} - {8'd0, CH_ZERO};
    d_units = {8'd0, cmd.arg_third}  - {8'd0, CH_ZERO};
    acc     = 16'(d_hund * 16'd10) + d_tens;
    acc     = 16'(acc * 16'd10) + d_units;
  end

  always_comb begin
    entry.arg0   = cmd.arg_first;
    entry.arg1   = cmd.arg_second;
    entry.arg2   = cmd.command_byte;
    entry.digits = acc;
    if (!cmd.kind) begin
      entry.op = OP_TICK;
    end else begin
      case (cmd.command_byte)
        CH_P:    entry.op = OP_PURGE;
        CH_V:    entry.op = OP_VALVE;
        CH_Q:    entry.op = OP_QUERY;
        CH_T:    entry.op = OP_TIME;
        CH_I:    entry.op = OP_IDENT;
        CH_S:    entry.op = OP_STOP;
        default: entry.op = OP_ECHO;
      endcase
    end
  end

endmodule

### rtl/ppvc_queue.sv
module ppvc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ppvc_pkg::ppvc_entry_t push_entry,
  input  logic                  pop,
  output ppvc_pkg::ppvc_entry_t head,
  output ppvc_pkg::ppvc_qstat_t qstat
);
  import ppvc_pkg::*;

  ppvc_entry_t slots [QUEUE_DEPTH];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head        = slots[rd_ptr];
  assign qstat.empty = (count == 2'd0);
  assign qstat.full  = (count == 2'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/ppvc_back.sv
module ppvc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  ppvc_pkg::ppvc_entry_t head,
  input  ppvc_pkg::ppvc_qstat_t qstat,
  output logic                  pop,
  ppvc_rep_if.source            rep
);
  import ppvc_pkg::*;

  logic [7:0]  ticks_per_second;
  logic        stopped, stopped_next;
  logic        purging, purging_next;
  logic [15:0] purge_seconds_set, purge_seconds_set_next;
  logic [15:0] seconds_elapsed, seconds_elapsed_next;
  logic [7:0]  tick_count, tick_count_next;
  logic        valve_state, valve_state_next;
  logic        pump_state, pump_state_next;
  logic        led_state, led_state_next;

  // Remaining time kept registered as sign and magnitude; a positive magnitude clamps at 999
  logic        time_neg, time_neg_next;
  logic [15:0] time_mag, time_mag_next;
  logic [15:0] diff_next;

  logic [31:0] hund_prod;
  logic [3:0]  hund;
  logic [6:0]  rem;
  logic [17:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  units;

  logic        out_valid;
  logic [1:0]  len;
  logic [7:0]  r0, r1, r2;

  assign pop = !qstat.empty && (!out_valid || rep.ready);

  // Split the magnitude into digits by reciprocal multiplication
  always_comb begin
    hund_prod = 32'(time_mag) * 32'd5243;
    hund      = 4'(hund_prod >> 19);
    rem       = 7'(time_mag - 16'(hund_prod >> 19) * 16'd100);
    tens_prod = 18'(rem) * 18'd205;
    tens      = 4'(tens_prod >> 11);
    units     = 4'(rem - 7'(tens) * 7'd10);
  end

  always_comb begin
    stopped_next           = stopped;
    purging_next           = purging;
    purge_seconds_set_next = purge_seconds_set;
    seconds_elapsed_next   = seconds_elapsed;
    tick_count_next        = tick_count;
    valve_state_next       = valve_state;
    pump_state_next        = pump_state;
    led_state_next         = led_state;
    len = LEN_NONE;
    r0  = 8'd0;
    r1  = 8'd0;
    r2  = 8'd0;
    if (pop) begin
      case (head.op)
        OP_TICK: begin
          if (purging) begin
            led_state_next  = !led_state;
            pump_state_next = 1'b1;
            tick_count_next = tick_count + 8'd1;
            if (tick_count_next > ticks_per_second) begin
              seconds_elapsed_next = seconds_elapsed + 16'd1;
              tick_count_next      = 8'd0;
            end
            if (seconds_elapsed_next > purge_seconds_set) begin
              pump_state_next      = 1'b0;
              purging_next         = 1'b0;
              seconds_elapsed_next = 16'd0;
              stopped_next         = 1'b1;
            end
          end
        end
        OP_PURGE: begin
          len = LEN_THREE;
          if (!valve_state) begin
            purging_next           = 1'b1;
            purge_seconds_set_next = head.digits;
            stopped_next           = 1'b0;
            r0 = CH_ZERO;
            r1 = CH_ZERO;
            r2 = CH_ONE;
          end else begin
            r0 = CH_V;
            r1 = CH_L;
            r2 = CH_V;
          end
        end
        OP_VALVE: begin
          if (head.arg0 == CH_S) valve_state_next = 1'b1;
          if (head.arg0 == CH_P) valve_state_next = 1'b0;
        end
        OP_QUERY: begin
          len = LEN_THREE;
          r0  = pump_state ? CH_ONE : CH_ZERO;
          r1  = CH_X;
          r2  = valve_state ? CH_ONE : CH_ZERO;
        end
        OP_TIME: begin
          len = LEN_THREE;
          r0  = time_neg ? CH_MINUS : CH_ZERO + 8'(hund);
          r1  = CH_ZERO + 8'(tens);
          r2  = CH_ZERO + 8'(units);
        end
        OP_IDENT: begin
          len = LEN_TWO;
          r0  = CH_BIG_O;
          r1  = CH_K;
        end
        OP_STOP: begin
          stopped_next           = 1'b1;
          purging_next           = 1'b0;
          purge_seconds_set_next = 16'd0;
          seconds_elapsed_next   = 16'd0;
        end
        default: begin
          len = LEN_THREE;
          r0  = head.arg2;
          r1  = head.arg0;
          r2  = head.arg1;
        end
      endcase
      // Purge and stop rules applied after every word
      if (!stopped_next && purging_next) begin
        pump_state_next  = 1'b1;
        valve_state_next = 1'b0;
      end
      if (stopped_next) begin
        pump_state_next        = 1'b0;
        led_state_next         = 1'b1;
        purging_next           = 1'b0;
        purge_seconds_set_next = 16'd0;
        seconds_elapsed_next   = 16'd0;
      end
    end
  end

  always_comb begin
    diff_next     = purge_seconds_set_next - seconds_elapsed_next;
    time_neg_next = diff_next[15];
    if (diff_next[15]) begin
      time_mag_next = 16'd0 - diff_next;
    end else if (diff_next > TIME_SAT) begin
      time_mag_next = TIME_SAT;
    end else begin
      time_mag_next = diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second  <= TPS_RESET;
      stopped           <= 1'b1;
      purging           <= 1'b0;
      purge_seconds_set <= 16'd0;
      seconds_elapsed   <= 16'd0;
      tick_count        <= 8'd0;
      valve_state       <= 1'b0;
      pump_state        <= 1'b0;
      led_state         <= 1'b1;
      time_neg          <= 1'b0;
      time_mag          <= 16'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) ticks_per_second <= cfg_wr_data;
      stopped           <= stopped_next;
      purging           <= purging_next;
      purge_seconds_set <= purge_seconds_set_next;
      seconds_elapsed   <= seconds_elapsed_next;
      tick_count        <= tick_count_next;
      valve_state       <= valve_state_next;
      pump_state        <= pump_state_next;
      led_state         <= led_state_next;
      time_neg          <= time_neg_next;
      time_mag          <= time_mag_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (rep.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rep.reply_length     <= len;
      rep.reply_zero       <= r0;
      rep.reply_one        <= r1;
      rep.reply_two        <= r2;
      rep.pump_on          <= pump_state_next;
      rep.valve_to_sampler <= valve_state_next;
      rep.status_led       <= led_state_next;
    end
  end

  assign rep.valid = out_valid;

endmodule

### rtl/purge_pump_valve_controller.sv
// Purge pump and valve controller.
//
// Channels: cmd takes one word per item, either a timer tick (kind = 0) or a
// four-byte ASCII command (kind = 1). rep returns exactly one word per item:
// up to three reply bytes with their count, plus the pump, valve and LED
// outputs as they stand after that item. cfg_wr_en / cfg_wr_data write the
// prescaler limit (ticks per second) and take effect at once.
//
// A word accepted on cmd passes through the front queue and then the output
// register before it is shown on rep.
// Throughput: one word per cycle while rep is not stalled; the back end updates
// the controller state as each word leaves the queue.
//
// Reset (synchronous, active high): stopped, pump off, LED on, valve toward
// the pump, prescaler limit 30, queue and output register empty.
//
// Receiver stall: the output register holds its word; the two-entry queue
// keeps taking words until it fills, then cmd.ready drops.
module purge_pump_valve_controller (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  ppvc_cmd_if.sink   cmd,
  ppvc_rep_if.source rep
);
  import ppvc_pkg::*;

  logic        push;
  logic        pop;
  ppvc_entry_t push_entry;
  ppvc_entry_t head;
  ppvc_qstat_t qstat;

  // Classify the incoming word and parse its digits
  ppvc_front u_front (
    .cmd   (cmd),
    .qstat (qstat),
    .push  (push),
    .entry (push_entry)
  );

  // Decouple intake from execution
  ppvc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // Advance controller state and register the reply word
  ppvc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .rep         (rep)
  );

  // The pump never runs with the valve toward the sampler
  a_pump_valve: assert property (@(posedge clk) disable iff (rst)
    rep.valid && rep.pump_on |-> !rep.valve_to_sampler)
    else $error("pump on with valve toward sampler");

  // Bytes beyond the reply length are zero
  a_len_none: assert property (@(posedge clk) disable iff (rst)
    rep.valid && rep.reply_length == LEN_NONE |->
      rep.reply_zero == 8'd0 && rep.reply_one == 8'd0 && rep.reply_two == 8'd0)
    else $error("reply bytes set with zero length");

  a_len_two: assert property (@(posedge clk) disable iff (rst)
    rep.valid && rep.reply_length == LEN_TWO |-> rep.reply_two == 8'd0)
    else $error("third reply byte set with length two");

  // The queue never takes a word while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !push)
    else $error("queue overflow");

endmodule
